/* rtl/core/crfw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package crfw_pkg;

  // Coordinate width; surface registers keep at most 12 bits of it.
  localparam int COORD_BITS = 12;
  localparam int DIM_BITS   = (COORD_BITS < 12) ? COORD_BITS : 12;

  localparam int ADDR_BITS      = 32;
  localparam int WORD_ADDR_BITS = ADDR_BITS - 2;
  localparam int RECT_BITS      = 16;
  localparam int CLIP_BITS      = RECT_BITS + 2;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_ADDRESS   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SURFACE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SURFACE_HEIGHT = 2'd2;

endpackage

`default_nettype wire

/* rtl/core/clipped_rect_fill_writer.sv */
// A tick transaction shows its write on the result port in the cycle after acceptance.
// Throughput: one transaction per cycle unless stalled; job state and output register both
// update in the acceptance cycle, with one 12x12 multiply plus adds on the start path.
// Input stalls only while a finished write sits in the output register and is stalled.
// Reset (rst, synchronous, active high) clears the configuration and job registers,
// drops any job and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module clipped_rect_fill_writer
  import crfw_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  // item channel
  input  wire logic                      item_valid,
  output logic                           item_stall,
  input  wire logic                      kind,
  input  wire logic signed [RECT_BITS-1:0] rect_x,
  input  wire logic signed [RECT_BITS-1:0] rect_y,
  input  wire logic signed [RECT_BITS-1:0] rect_w,
  input  wire logic signed [RECT_BITS-1:0] rect_h,
  input  wire logic [7:0]                fill_value,
  // result channel
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output logic [WORD_ADDR_BITS-1:0]      word_address,
  output logic [31:0]                    write_data,
  output logic [3:0]                     byte_enable,
  output logic                           last_write,
  // configuration channel
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [31:0]               cfg_data
);

  logic [ADDR_BITS-1:0] base_address;
  logic [DIM_BITS-1:0]  surface_width;
  logic [DIM_BITS-1:0]  surface_height;

  logic                 job_active;
  logic [ADDR_BITS-1:0] row_start_address;
  logic [ADDR_BITS-1:0] current_address;
  logic [DIM_BITS-1:0]  span_length;
  logic [DIM_BITS-1:0]  bytes_left_in_row;
  logic [DIM_BITS-1:0]  rows_left;
  logic [7:0]           held_fill_value;

  logic                 job_active_next;
  logic [ADDR_BITS-1:0] row_start_address_next;
  logic [ADDR_BITS-1:0] current_address_next;
  logic [DIM_BITS-1:0]  span_length_next;
  logic [DIM_BITS-1:0]  bytes_left_in_row_next;
  logic [DIM_BITS-1:0]  rows_left_next;
  logic [7:0]           held_fill_value_next;

  logic                 item_accept;
  logic                 emit;
  logic [3:0]           enable_calc;
  logic                 last_calc;

  assign cfg_ready   = 1'b1;
  assign item_stall  = result_valid & result_stall;
  assign item_accept = item_valid & ~item_stall;
  assign emit        = item_accept & (kind == KIND_TICK) & job_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= '0;
      surface_width  <= '0;
      surface_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_ADDRESS:   base_address   <= cfg_data;
        REG_SURFACE_WIDTH:  surface_width  <= cfg_data[DIM_BITS-1:0];
        REG_SURFACE_HEIGHT: surface_height <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [CLIP_BITS-1:0] x0;
    logic signed [CLIP_BITS-1:0] y0;
    logic signed [CLIP_BITS-1:0] x1;
    logic signed [CLIP_BITS-1:0] y1;
    logic signed [CLIP_BITS-1:0] width_s;
    logic signed [CLIP_BITS-1:0] height_s;
    logic [DIM_BITS-1:0]         x0_u;
    logic [DIM_BITS-1:0]         y0_u;
    logic [2*DIM_BITS-1:0]       row_offset;
    logic [ADDR_BITS-1:0]        start_address;
    logic [1:0]                  offset;
    logic [2:0]                  room;
    logic [2:0]                  n;
    logic [4:0]                  n_mask;
    logic [7:0]                  lane_mask;
    logic [DIM_BITS-1:0]         bytes_after;
    logic [DIM_BITS-1:0]         rows_after;
    logic [ADDR_BITS-1:0]        next_row;

    job_active_next        = job_active;
    row_start_address_next = row_start_address;
    current_address_next   = current_address;
    span_length_next       = span_length;
    bytes_left_in_row_next = bytes_left_in_row;
    rows_left_next         = rows_left;
    held_fill_value_next   = held_fill_value;

    // clip to the surface
    width_s  = $signed(CLIP_BITS'(surface_width));
    height_s = $signed(CLIP_BITS'(surface_height));
    x0 = CLIP_BITS'(rect_x);
    y0 = CLIP_BITS'(rect_y);
    x1 = CLIP_BITS'(rect_x) + CLIP_BITS'(rect_w);
    y1 = CLIP_BITS'(rect_y) + CLIP_BITS'(rect_h);
    if (x0 < 0) x0 = '0;
    if (y0 < 0) y0 = '0;
    if (x1 > width_s) x1 = width_s;
    if (y1 > height_s) y1 = height_s;
    x0_u          = x0[DIM_BITS-1:0];
    y0_u          = y0[DIM_BITS-1:0];
    row_offset    = y0_u * surface_width;
    start_address = base_address + ADDR_BITS'(row_offset) + ADDR_BITS'(x0_u);

    // one masked word of the current span
    offset    = current_address[1:0];
    room      = 3'd4 - 3'(offset);
    n         = (bytes_left_in_row < DIM_BITS'(room)) ? bytes_left_in_row[2:0] : room;
    n_mask    = (5'd1 << n) - 5'd1;
    lane_mask = {4'b0, n_mask[3:0]} << offset;
    enable_calc = lane_mask[3:0];
    bytes_after = bytes_left_in_row - DIM_BITS'(n);
    rows_after  = rows_left - DIM_BITS'(1);
    next_row    = row_start_address + ADDR_BITS'(surface_width);
    last_calc   = 1'b0;

    if (item_accept) begin
      if (kind == KIND_START) begin
        if (x0 >= x1 || y0 >= y1) begin
          job_active_next = 1'b0;
        end else begin
          job_active_next        = 1'b1;
          held_fill_value_next   = fill_value;
          row_start_address_next = start_address;
          current_address_next   = start_address;
          span_length_next       = DIM_BITS'(x1 - x0);
          bytes_left_in_row_next = DIM_BITS'(x1 - x0);
          rows_left_next         = DIM_BITS'(y1 - y0);
        end
      end else if (job_active) begin
        bytes_left_in_row_next = bytes_after;
        current_address_next   = current_address + ADDR_BITS'(n);
        if (bytes_after == '0) begin
          rows_left_next = rows_after;
          if (rows_after == '0) begin
            last_calc       = 1'b1;
            job_active_next = 1'b0;
          end else begin
            row_start_address_next = next_row;
            current_address_next   = next_row;
            bytes_left_in_row_next = span_length;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_active        <= 1'b0;
      row_start_address <= '0;
      current_address   <= '0;
      span_length       <= '0;
      bytes_left_in_row <= '0;
      rows_left         <= '0;
      held_fill_value   <= '0;
    end else begin
      job_active        <= job_active_next;
      row_start_address <= row_start_address_next;
      current_address   <= current_address_next;
      span_length       <= span_length_next;
      bytes_left_in_row <= bytes_left_in_row_next;
      rows_left         <= rows_left_next;
      held_fill_value   <= held_fill_value_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      word_address <= current_address[ADDR_BITS-1:2];
      write_data   <= {4{held_fill_value}};
      byte_enable  <= enable_calc;
      last_write   <= last_calc;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/crfw_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module crfw_checker
  import crfw_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      item_valid,
  input wire logic                      item_stall,
  input wire logic                      kind,
  input wire logic                      result_valid,
  input wire logic                      result_stall,
  input wire logic [WORD_ADDR_BITS-1:0] word_address,
  input wire logic [31:0]               write_data,
  input wire logic [3:0]                byte_enable,
  input wire logic                      last_write
);

  // a stalled write holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(word_address) && $stable(byte_enable) && $stable(last_write))
    else $error("stalled write changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("write shown right after reset");

  // the input side only waits on a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without a waiting write");

  // a start transaction never causes a write
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && kind == KIND_START && !result_valid |=> !result_valid)
    else $error("write after a start transaction");

  a_write_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> byte_enable != 4'b0000 &&
      write_data[31:24] == write_data[7:0] && write_data[23:16] == write_data[7:0] &&
      write_data[15:8] == write_data[7:0])
    else $error("malformed write");

endmodule

bind clipped_rect_fill_writer crfw_checker u_crfw_checker (.*);

`default_nettype wire

/* tb/clipped_rect_fill_writer_tb.sv */
`timescale 1ns / 1ps

module clipped_rect_fill_writer_tb;
  import crfw_pkg::*;

  localparam int ITEM_TARGET    = 1650;
  localparam int PHASE_ITEMS    = 150;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 4;

  // index past the last register; writes to it must change nothing
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_t;

  typedef struct {
    logic [WORD_ADDR_BITS-1:0] waddr;
    logic [31:0]               data;
    logic [3:0]                be;
    logic                      last;
  } fill_write_t;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic kind;
  logic signed [RECT_BITS-1:0] rect_x;
  logic signed [RECT_BITS-1:0] rect_y;
  logic signed [RECT_BITS-1:0] rect_w;
  logic signed [RECT_BITS-1:0] rect_h;
  logic [7:0] fill_value;
  logic result_valid;
  logic result_stall;
  logic [WORD_ADDR_BITS-1:0] word_address;
  logic [31:0] write_data;
  logic [3:0] byte_enable;
  logic last_write;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [31:0] cfg_data;

  clipped_rect_fill_writer uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .rect_w       (rect_w),
    .rect_h       (rect_h),
    .fill_value   (fill_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .word_address (word_address),
    .write_data   (write_data),
    .byte_enable  (byte_enable),
    .last_write   (last_write),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Tracks the fill job the way the block should, and queues the word writes it owes.
  class fill_scoreboard;
    logic [31:0]         base_addr;
    logic [DIM_BITS-1:0] surf_w;
    logic [DIM_BITS-1:0] surf_h;
    bit                  job_on;
    logic [31:0]         row_addr;
    logic [31:0]         cur_addr;
    logic [DIM_BITS-1:0] span;
    logic [DIM_BITS-1:0] row_left;
    logic [DIM_BITS-1:0] rows_left;
    logic [7:0]          fill;
    fill_write_t         pending_writes[$];
    int                  mismatches;
    int                  writes_checked;
    int                  items_used;

    function new();
      base_addr = 0;
      surf_w = 0;
      surf_h = 0;
      job_on = 0;
      row_addr = 0;
      cur_addr = 0;
      span = 0;
      row_left = 0;
      rows_left = 0;
      fill = 0;
      mismatches = 0;
      writes_checked = 0;
      items_used = 0;
    endfunction

    function void apply_register(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] d);
      case (idx)
        REG_BASE_ADDRESS:   base_addr = d;
        REG_SURFACE_WIDTH:  surf_w = d[DIM_BITS-1:0];
        REG_SURFACE_HEIGHT: surf_h = d[DIM_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic k, logic signed [RECT_BITS-1:0] rx,
                            logic signed [RECT_BITS-1:0] ry, logic signed [RECT_BITS-1:0] rw,
                            logic signed [RECT_BITS-1:0] rh, logic [7:0] f);
      int x0;
      int y0;
      int x1;
      int y1;
      int n;
      int off;
      fill_write_t w;
      if (k == KIND_START) begin
        items_used++;
        x0 = rx;
        y0 = ry;
        x1 = x0 + int'(rw);
        y1 = y0 + int'(rh);
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > int'(surf_w)) x1 = surf_w;
        if (y1 > int'(surf_h)) y1 = surf_h;
        if (x0 >= x1 || y0 >= y1) begin
          job_on = 0;
          return;
        end
        fill = f;
        row_addr = base_addr + 32'(y0 * int'(surf_w) + x0);
        cur_addr = row_addr;
        span = DIM_BITS'(x1 - x0);
        row_left = span;
        rows_left = DIM_BITS'(y1 - y0);
        job_on = 1;
      end else if (job_on) begin
        items_used++;
        off = cur_addr[1:0];
        n = 4 - off;
        if (int'(row_left) < n) n = row_left;
        w.waddr = cur_addr[31:2];
        w.data = {4{fill}};
        w.be = 4'(((1 << n) - 1) << off);
        w.last = 1'b0;
        row_left = row_left - DIM_BITS'(n);
        cur_addr = cur_addr + 32'(n);
        if (row_left == 0) begin
          rows_left = rows_left - 1'b1;
          if (rows_left == 0) begin
            w.last = 1'b1;
            job_on = 0;
          end else begin
            row_addr = row_addr + 32'(surf_w);
            cur_addr = row_addr;
            row_left = span;
          end
        end
        pending_writes.push_back(w);
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_write(logic [WORD_ADDR_BITS-1:0] a, logic [31:0] d, logic [3:0] be,
                     logic last);
      fill_write_t e;
      writes_checked++;
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("write to word %h with nothing expected", a));
        return;
      end
      e = pending_writes.pop_front();
      if (a !== e.waddr)
        report_mismatch($sformatf("word_address %h, expected %h", a, e.waddr));
      if (d !== e.data)
        report_mismatch($sformatf("write_data %h, expected %h (word %h)", d, e.data, e.waddr));
      if (be !== e.be)
        report_mismatch($sformatf("byte_enable %b, expected %b (word %h)", be, e.be, e.waddr));
      if (last !== e.last)
        report_mismatch($sformatf("last_write %b, expected %b (word %h)", last, e.last,
                                  e.waddr));
    endtask
  endclass

  fill_scoreboard sb;
  bit hold_req = 0;
  int burst_left = 0;
  int accepted_items = 0;
  int settings_used = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_write(word_address, write_data, byte_enable, last_write);
  end

  // receiver back-pressure
  initial begin
    stall_mode_t mode;
    int left;
    int cyc;
    mode = STALL_NONE;
    left = 0;
    cyc = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        // long hold-off so the output fills and the input backs up
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 0;
      end
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(10, 150);
      end
      left--;
      case (mode)
        STALL_NONE:  result_stall <= 1'b0;
        STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
        default:     result_stall <= ((cyc % 7) < 3);
      endcase
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL clipped_rect_fill_writer");
    $finish;
  end

  task automatic send_item(logic k, logic signed [RECT_BITS-1:0] x,
                           logic signed [RECT_BITS-1:0] y, logic signed [RECT_BITS-1:0] w,
                           logic signed [RECT_BITS-1:0] h, logic [7:0] f);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    kind <= k;
    rect_x <= x;
    rect_y <= y;
    rect_w <= w;
    rect_h <= h;
    fill_value <= f;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(k, x, y, w, h, f);
    burst_left--;
    accepted_items++;
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom));
  endtask

  // start a fill, tick it until done or cap, then send extra more ticks, idle ones if the job finished
  task automatic run_job(logic signed [RECT_BITS-1:0] x, logic signed [RECT_BITS-1:0] y,
                         logic signed [RECT_BITS-1:0] w, logic signed [RECT_BITS-1:0] h,
                         logic [7:0] f, int cap, int extra);
    int n;
    n = 0;
    send_item(KIND_START, x, y, w, h, f);
    while (sb.job_on && n < cap) begin
      send_tick();
      n++;
    end
    repeat (extra) send_tick();
  endtask

  task automatic random_job(int sw, int sh);
    logic signed [RECT_BITS-1:0] x;
    logic signed [RECT_BITS-1:0] y;
    logic signed [RECT_BITS-1:0] w;
    logic signed [RECT_BITS-1:0] h;
    int pick;
    int cap;
    int extra;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      x = 16'($urandom);
      y = 16'($urandom);
      w = 16'($urandom);
      h = 16'($urandom);
    end else if (pick == 1) begin
      x = 16'($urandom_range(0, sw));
      y = 16'($urandom_range(0, sh));
      w = 16'(-int'($urandom_range(0, 40)));
      h = 16'(int'($urandom_range(0, 12)) - 6);
    end else begin
      x = 16'(int'($urandom_range(0, sw + 8)) - 6);
      y = 16'(int'($urandom_range(0, sh + 6)) - 4);
      w = 16'($urandom_range(1, 24));
      h = 16'($urandom_range(1, 6));
    end
    cap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : 600;
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    run_job(x, y, w, h, 8'($urandom), cap, extra);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_register(idx, d);
  endtask

  // upper bits of the size registers are junk the block must drop
  task automatic set_surface(logic [31:0] b, int wd, int ht);
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom);
    write_reg(REG_BASE_ADDRESS, b);
    write_reg(REG_SURFACE_WIDTH, {($urandom_range(0, 1) ? 20'($urandom) : 20'h0), 12'(wd)});
    write_reg(REG_SURFACE_HEIGHT, {($urandom_range(0, 1) ? 20'($urandom) : 20'h0), 12'(ht)});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // empty start drops any job, then drain before the next register write
  task automatic end_phase();
    send_item(KIND_START, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'($urandom));
    item_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int sw;
    int sh;
    int phase_start;
    bit first_random;
    logic [31:0] b;
    sb = new();
    rst <= 1'b1;
    item_valid <= 1'b0;
    kind <= KIND_TICK;
    rect_x <= '0;
    rect_y <= '0;
    rect_w <= '0;
    rect_h <= '0;
    fill_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BASE_ADDRESS;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // surface registers still at reset: nothing can be drawn
    run_job(16'sd3, 16'sd3, 16'sd4, 16'sd4, 8'h11, 10, 2);
    end_phase();

    // directed: small surface, base offset 2 so spans start mid-word
    set_surface(32'h0000_0102, 13, 7);
    send_tick();
    run_job(16'sd0, 16'sd0, 16'sd0, 16'sd3, 8'h21, 10, 0);
    run_job(16'sd2, 16'sd1, 16'sd5, -16'sd1, 8'h22, 10, 0);
    run_job(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 8'h23, 10, 0);
    run_job(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 8'h24, 10, 0);
    run_job(-16'sd5, -16'sd3, 16'sd32767, 16'sd32767, 8'hFF, 3, 0);
    run_job(16'sd11, 16'sd5, 16'sd10, 16'sd10, 8'h00, 20, 1);
    run_job(16'sd1, 16'sd2, 16'sd9, 16'sd2, 8'h5A, 20, 0);
    run_job(16'sd0, 16'sd0, 16'sd13, 16'sd1, 8'hC3, 1, 0);
    run_job(16'sd4, 16'sd4, -16'sd1, 16'sd2, 8'h3C, 0, 1);
    end_phase();

    // largest surface, base just below the address wrap
    set_surface(32'hFFFF_FFFE, 4095, 4095);
    run_job(16'sd4090, 16'sd4093, 16'sd100, 16'sd100, 8'hA5, 20, 0);
    run_job(16'sd0, 16'sd0, 16'sd3, 16'sd1, 8'h96, 20, 0);
    run_job(-16'sd1, -16'sd1, 16'sd1, 16'sd1, 8'h69, 20, 1);
    run_job(16'sd4094, 16'sd4094, 16'sd1, 16'sd1, 8'h81, 20, 0);
    end_phase();

    // zero width, then zero height
    set_surface(32'h0000_0000, 0, 9);
    run_job(16'sd0, 16'sd0, 16'sd5, 16'sd5, 8'h42, 10, 1);
    end_phase();
    set_surface(32'hFFFF_FFFF, 7, 0);
    run_job(16'sd0, 16'sd0, 16'sd5, 16'sd5, 8'h24, 10, 1);
    end_phase();

    first_random = 1;
    while (sb.items_used < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) begin
        sw = $urandom_range(2000, 4095);
        sh = $urandom_range(1, 4);
      end else begin
        sw = $urandom_range(1, 40);
        sh = $urandom_range(1, 20);
      end
      b = ($urandom_range(0, 3) == 0) ? (32'hFFFF_FF00 | 32'($urandom_range(0, 255)))
                                      : $urandom;
      set_surface(b, sw, sh);
      if (first_random) hold_req = 1;
      first_random = 0;
      phase_start = sb.items_used;
      while (sb.items_used - phase_start < PHASE_ITEMS && sb.items_used < ITEM_TARGET)
        random_job(sw, sh);
      end_phase();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d transactions (%0d starts or live ticks) over %0d surface settings",
             accepted_items, sb.items_used, settings_used);
    $display("checked %0d word writes, %0d mismatches", sb.writes_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_writes.size() == 0)
      $display("PASS clipped_rect_fill_writer");
    else
      $display("FAIL clipped_rect_fill_writer");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/crfw_pkg.sv
rtl/core/clipped_rect_fill_writer.sv
rtl/core/crfw_checker.sv
tb/clipped_rect_fill_writer_tb.sv
